[rtl/core/itad_pkg.sv]
`timescale 1ns / 1ps

package itad_pkg;

   localparam int MAX_DIGITS   = 32;
   localparam int RESULT_LIMIT = 32;
   localparam int VALUE_W      = 32;
   localparam int CHAR_W       = 7;
   localparam int DIGIT_W      = 4;
   localparam int MIN_DIG_W    = 6;
   localparam int COUNT_W      = $clog2(RESULT_LIMIT + 1);
   localparam int DIG_IDX_W    = $clog2(RESULT_LIMIT);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

   // floor(v / 10) == (v * RECIP_10) >> RECIP_10_SHIFT for every 32-bit v
   localparam logic [VALUE_W-1:0] RECIP_10       = 32'hcccc_cccd;
   localparam int                 RECIP_10_SHIFT = 35;

   typedef enum logic [1:0] {
      RADIX_BIN = 2'd0,
      RADIX_DEC = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIGIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic      load_q;
      radix_type radix;
   } div_ctrl_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < 4'd10) begin
         return CHAR_ZERO + d_ext;
      end else begin
         return CHAR_A + d_ext - 7'd10;
      end
   endfunction

endpackage

[rtl/core/itad_req_if.sv]
`timescale 1ns / 1ps

interface itad_req_if;
   import itad_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [VALUE_W-1:0]     value;
   logic                   is_signed;
   logic [1:0]             radix_code;
   logic [MIN_DIG_W-1:0]   min_digits;

   modport source (output valid, value, is_signed, radix_code, min_digits, input ready);
   modport sink   (input valid, value, is_signed, radix_code, min_digits, output ready);
endinterface

[rtl/core/itad_rsp_if.sv]
`timescale 1ns / 1ps

interface itad_rsp_if;
   import itad_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   ascii_char;
   logic                last_char;

   modport source (output valid, ascii_char, last_char, input ready);
   modport sink   (input valid, ascii_char, last_char, output ready);
endinterface

[rtl/core/itad_div.sv]
`timescale 1ns / 1ps

module itad_div
   import itad_pkg::*;
(
   input  logic                 clock,
   input  div_ctrl_type         ctrl,
   input  logic [VALUE_W-1:0]   dividend,
   output logic [VALUE_W-1:0]   quotient,
   output logic [DIGIT_W-1:0]   remainder
);

   logic [2*VALUE_W-1:0] prod;
   logic [VALUE_W-1:0]   q_dec_ff;
   logic [VALUE_W-1:0]   q_dec_in;
   logic [VALUE_W-1:0]   diff;

   assign prod     = {{VALUE_W{1'b0}}, dividend} * {{VALUE_W{1'b0}}, RECIP_10};
   assign q_dec_in = VALUE_W'(prod[2*VALUE_W-1:RECIP_10_SHIFT]);

   // reciprocal product is registered before the remainder step
   always_ff @(posedge clock) begin
      if (ctrl.load_q) begin
         q_dec_ff <= q_dec_in;
      end
   end

   // remainder of a decimal step: v - 8q - 2q
   assign diff = dividend - {q_dec_ff[VALUE_W-4:0], 3'b000} - {q_dec_ff[VALUE_W-2:0], 1'b0};

   always_comb begin
      case (ctrl.radix)
         RADIX_BIN: begin
            quotient  = {1'b0, dividend[VALUE_W-1:1]};
            remainder = {3'b000, dividend[0]};
         end
         RADIX_DEC: begin
            quotient  = q_dec_ff;
            remainder = diff[DIGIT_W-1:0];
         end
         default: begin
            quotient  = {4'b0000, dividend[VALUE_W-1:4]};
            remainder = dividend[DIGIT_W-1:0];
         end
      endcase
   end

endmodule

[rtl/core/integer_to_ascii_digits_core.sv]
`timescale 1ns / 1ps

// Converts a 32-bit value to ASCII text in binary, decimal or lower-case hex,
// one character per rsp transaction, most significant first, with last_char on
// the final one. Signed decimal negatives get a leading '-'. At least
// min_digits digits appear, capped at 32 (31 for a negative) and at least one,
// zero-padded after the sign. Digits are produced least significant first
// into a 32-entry digit buffer by one shared divide unit: a shift and mask
// step per digit for binary and hex, a registered reciprocal multiply and then
// a remainder step per digit for decimal. The buffer is then read back one
// character per cycle while the output register is free. The next req
// transaction is taken only after conversion and readout; req is not ready
// during them, and the last character may still wait in the output register.
module integer_to_ascii_digits_core
   import itad_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   itad_req_if.sink     req_if,
   itad_rsp_if.source   rsp_if
);

   state_type                 state_ff, state_in;

   logic [VALUE_W-1:0]        v_ff;
   radix_type                 radix_ff;
   logic                      sign_pend_ff;
   logic [COUNT_W-1:0]        mind_ff;
   logic [COUNT_W-1:0]        nd_ff;
   logic [DIGIT_W-1:0]        digs_ff [RESULT_LIMIT];

   logic                      rsp_valid_ff;
   logic [CHAR_W-1:0]         char_ff;
   logic                      last_ff;

   logic                      req_ready;
   logic                      accept;
   logic                      digit_wr;
   logic                      emit_load;
   logic                      out_free;

   radix_type                 radix_sel;
   logic                      neg_in;
   logic [VALUE_W-1:0]        mag_in;
   logic [COUNT_W-1:0]        m_sat;
   logic [COUNT_W-1:0]        cap;
   logic [COUNT_W-1:0]        mind_in;

   div_ctrl_type              div_ctrl;
   logic [VALUE_W-1:0]        div_q;
   logic [DIGIT_W-1:0]        div_rem;
   logic [COUNT_W-1:0]        nd_plus;
   logic [COUNT_W-1:0]        nd_minus;
   logic                      more_digits;

   itad_div u_div (
      .clock     (clock),
      .ctrl      (div_ctrl),
      .dividend  (v_ff),
      .quotient  (div_q),
      .remainder (div_rem)
   );

   // request decode
   always_comb begin
      case (req_if.radix_code)
         RADIX_BIN: radix_sel = RADIX_BIN;
         RADIX_DEC: radix_sel = RADIX_DEC;
         default:   radix_sel = RADIX_HEX;
      endcase
      neg_in = (radix_sel == RADIX_DEC) && req_if.is_signed && req_if.value[VALUE_W-1];
      mag_in = neg_in ? (~req_if.value + 32'd1) : req_if.value;

      m_sat = (req_if.min_digits > MIN_DIG_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS)
                                                           : COUNT_W'(req_if.min_digits);
      cap   = COUNT_W'(RESULT_LIMIT) - {{(COUNT_W-1){1'b0}}, neg_in};
      mind_in = (m_sat > cap) ? cap : m_sat;
      if (mind_in == '0) begin
         mind_in = COUNT_W'(1);
      end
   end

   assign nd_plus     = nd_ff + COUNT_W'(1);
   assign nd_minus    = nd_ff - COUNT_W'(1);
   // zero quotient still yields '0' digits, which covers padding
   assign more_digits = ((div_q != '0) || (nd_plus < mind_ff))
                        && (nd_plus < COUNT_W'(RESULT_LIMIT));
   assign out_free    = !rsp_valid_ff || rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               state_in = (radix_sel == RADIX_DEC) ? ST_MUL : ST_DIGIT;
            end
         end
         ST_MUL: begin
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (more_digits) begin
               state_in = (radix_ff == RADIX_DEC) ? ST_MUL : ST_DIGIT;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && !sign_pend_ff && (nd_ff == COUNT_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready       = 1'b0;
      digit_wr        = 1'b0;
      emit_load       = 1'b0;
      div_ctrl.load_q = 1'b0;
      div_ctrl.radix  = radix_ff;
      unique case (state_ff)
         ST_IDLE:  req_ready       = 1'b1;
         ST_MUL:   div_ctrl.load_q = 1'b1;
         ST_DIGIT: digit_wr        = 1'b1;
         ST_EMIT:  emit_load       = out_free;
         default:  req_ready       = 1'b0;
      endcase
   end

   assign accept       = req_if.valid && req_ready;
   assign req_if.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sign_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            sign_pend_ff <= neg_in;
         end else if (emit_load) begin
            sign_pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         v_ff     <= mag_in;
         radix_ff <= radix_sel;
         mind_ff  <= mind_in;
         nd_ff    <= '0;
      end else if (digit_wr) begin
         digs_ff[nd_ff[DIG_IDX_W-1:0]] <= div_rem;
         v_ff  <= div_q;
         nd_ff <= nd_plus;
      end else if (emit_load && !sign_pend_ff) begin
         nd_ff <= nd_minus;
      end

      if (emit_load) begin
         if (sign_pend_ff) begin
            char_ff <= CHAR_MINUS;
            last_ff <= 1'b0;
         end else begin
            char_ff <= digit_to_char(digs_ff[nd_minus[DIG_IDX_W-1:0]]);
            last_ff <= (nd_ff == COUNT_W'(1));
         end
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.ascii_char = char_ff;
   assign rsp_if.last_char  = last_ff;

endmodule
